>>> hw/rtl/dpi_pkg.sv
// dpi_pkg: types, constants and codes shared by the dual PI controller.
// Depends on nothing; imported by dpi_csr, dpi_core and the top level.
package dpi_pkg;

   localparam int DATA_WIDTH_DEF  = 32;
   localparam int INTEG_WIDTH_DEF = 48;
   localparam int GAIN_W          = 31;
   localparam int PERIOD_W        = 32;
   localparam int CSR_IDX_W       = 3;

   // Ta = 2.0e-4 s as Q0.32
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 32'd858993;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FLUX_KP   = 3'd0,
      CSR_FLUX_KI   = 3'd1,
      CSR_FLUX_KAW  = 3'd2,
      CSR_SPEED_KP  = 3'd3,
      CSR_SPEED_KI  = 3'd4,
      CSR_SPEED_KAW = 3'd5,
      CSR_LIMIT     = 3'd6,
      CSR_PERIOD    = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [GAIN_W-1:0]   flux_kp;
      logic [GAIN_W-1:0]   flux_ki;
      logic [GAIN_W-1:0]   flux_kaw;
      logic [GAIN_W-1:0]   speed_kp;
      logic [GAIN_W-1:0]   speed_ki;
      logic [GAIN_W-1:0]   speed_kaw;
      logic [GAIN_W-1:0]   limit;
      logic [PERIOD_W-1:0] period;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ERR,
      ST_MAG,
      ST_KP,
      ST_GT,
      ST_PL,
      ST_PH,
      ST_RND,
      ST_ACC,
      ST_SUM,
      ST_CLAMP,
      ST_DONE
   } state_type;

endpackage

>>> hw/rtl/dpi_mul.sv
// dpi_mul: shared 32x32 unsigned multiplier with registered product.
// Standalone; used by dpi_core for every product of both loops.
module dpi_mul (
   input  logic        clock,
   input  logic [31:0] mul_a,
   input  logic [31:0] mul_b,
   output logic [63:0] mul_p
);

   logic [63:0] prod_ff;
   logic [63:0] prod_in;

   assign prod_in = 64'(mul_a) * 64'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign mul_p = prod_ff;

endmodule

>>> hw/rtl/dpi_csr.sv
// dpi_csr: gain, limit and period registers with their write channel.
// Depends on dpi_pkg (cfg_type, csr_index_type, reset values).
module dpi_csr import dpi_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_FLUX_KP:   cfg_in.flux_kp   = csr_wdata[GAIN_W-1:0];
            CSR_FLUX_KI:   cfg_in.flux_ki   = csr_wdata[GAIN_W-1:0];
            CSR_FLUX_KAW:  cfg_in.flux_kaw  = csr_wdata[GAIN_W-1:0];
            CSR_SPEED_KP:  cfg_in.speed_kp  = csr_wdata[GAIN_W-1:0];
            CSR_SPEED_KI:  cfg_in.speed_ki  = csr_wdata[GAIN_W-1:0];
            CSR_SPEED_KAW: cfg_in.speed_kaw = csr_wdata[GAIN_W-1:0];
            CSR_LIMIT:     cfg_in.limit     = csr_wdata[GAIN_W-1:0];
            CSR_PERIOD:    cfg_in.period    = csr_wdata[PERIOD_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{flux_kp: '0, flux_ki: '0, flux_kaw: '0,
                     speed_kp: '0, speed_ki: '0, speed_kaw: '0,
                     limit: '0, period: PERIOD_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> hw/rtl/dpi_core.sv
// dpi_core: sequencer and datapath running both PI loops on one multiplier.
// Depends on dpi_pkg and instantiates dpi_mul.
module dpi_core import dpi_pkg::*; #(
   parameter int DATA_WIDTH       = DATA_WIDTH_DEF,
   parameter int INTEGRATOR_WIDTH = INTEG_WIDTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic signed [31:0] in_flux_target,
   input  logic signed [31:0] in_flux_measured,
   input  logic signed [31:0] in_speed_target,
   input  logic signed [31:0] in_speed_measured,
   output logic               out_valid,
   input  logic               out_ready,
   output logic signed [31:0] out_d_ref,
   output logic signed [31:0] out_q_ref,
   output logic               out_flux_clamped,
   output logic               out_speed_clamped
);

   localparam int ERR_W = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;
   localparam int IW    = INTEGRATOR_WIDTH;
   localparam int AW    = ((IW > 48) ? IW : 48) + 1;
   localparam int DW    = 66;
   localparam int RW    = 47;

   localparam logic signed [DW-1:0] ERR_HI = $signed((DW'(1) << (ERR_W - 1)) - DW'(1));
   localparam logic signed [DW-1:0] ERR_LO = ~ERR_HI;
   localparam logic [31:0]          LO_MAG = 32'(ERR_HI) + 32'd1;
   localparam logic signed [AW-1:0] INT_HI = $signed((AW'(1) << (IW - 1)) - AW'(1));
   localparam logic signed [AW-1:0] INT_LO = ~INT_HI;
   localparam logic signed [DW-1:0] S64_HI = $signed((DW'(1) << 63) - DW'(1));
   localparam logic signed [DW-1:0] S64_LO = ~S64_HI;

   state_type state_ff, state_in;
   logic loop_ff, loop_in;
   logic aw_ff, aw_in;
   logic signed [31:0] flx_tgt_ff, flx_tgt_in, flx_meas_ff, flx_meas_in;
   logic signed [31:0] spd_tgt_ff, spd_tgt_in, spd_meas_ff, spd_meas_in;
   logic signed [DW-1:0] diff_ff, diff_in;
   logic [31:0] mag_ff, mag_in;
   logic sgn_ff, sgn_in;
   logic [30:0] ph_ff, ph_in;
   logic [63:0] low_ff, low_in;
   logic [RW-1:0] rnd_ff, rnd_in, prop_ff, prop_in;
   logic signed [IW-1:0] flx_int_ff, flx_int_in, spd_int_ff, spd_int_in;
   logic signed [63:0] out_ff, out_in;
   logic signed [31:0] d_ff, d_in, q_ff, q_in;
   logic dflag_ff, dflag_in, qflag_ff, qflag_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_d_ff, rsp_d_in, rsp_q_ff, rsp_q_in;
   logic rsp_df_ff, rsp_df_in, rsp_qf_ff, rsp_qf_in;

   logic [31:0] mul_a, mul_b;
   logic [63:0] prod;
   logic done_go;
   logic [GAIN_W-1:0] kp_sel, gain_sel;
   logic signed [IW-1:0] integ_cur;
   logic signed [DW-1:0] err_raw, abs_diff, sum_raw, prop_s, clamp_ext;
   logic [63:0] p_sum, rnd_sum;
   logic signed [AW-1:0] acc_a, acc_r, acc_raw;
   logic signed [IW-1:0] acc_sat;
   logic signed [63:0] lim64, clamped;
   logic clamp_hit;

   dpi_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (prod)
   );

   assign done_go   = !rsp_valid_ff || out_ready;
   assign kp_sel    = loop_ff ? cfg.speed_kp : cfg.flux_kp;
   assign gain_sel  = aw_ff ? (loop_ff ? cfg.speed_kaw : cfg.flux_kaw)
                            : (loop_ff ? cfg.speed_ki : cfg.flux_ki);
   assign integ_cur = loop_ff ? spd_int_ff : flx_int_ff;
   assign err_raw   = loop_ff ? (DW'(spd_tgt_ff) - DW'(spd_meas_ff))
                              : (DW'(flx_tgt_ff) - DW'(flx_meas_ff));
   assign abs_diff  = diff_ff[DW-1] ? -diff_ff : diff_ff;
   assign p_sum     = prod + 64'd32768;
   assign rnd_sum   = prod + {32'd0, low_ff[63:32]};

   assign acc_a   = AW'(integ_cur);
   assign acc_r   = $signed({{(AW-RW){1'b0}}, rnd_ff});
   assign acc_raw = (sgn_ff ^ aw_ff) ? (acc_a - acc_r) : (acc_a + acc_r);
   assign acc_sat = (acc_raw > INT_HI) ? INT_HI[IW-1:0] :
                    (acc_raw < INT_LO) ? INT_LO[IW-1:0] : acc_raw[IW-1:0];

   assign prop_s  = $signed({{(DW-RW){1'b0}}, prop_ff});
   assign sum_raw = sgn_ff ? (DW'(integ_cur) - prop_s) : (DW'(integ_cur) + prop_s);

   assign lim64 = $signed({33'd0, cfg.limit});
   always_comb begin
      clamp_hit = 1'b1;
      if (out_ff > lim64) begin
         clamped = lim64;
      end else if (out_ff < -lim64) begin
         clamped = -lim64;
      end else begin
         clamped   = out_ff;
         clamp_hit = 1'b0;
      end
   end
   assign clamp_ext = DW'(clamped);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (in_valid) state_in = ST_ERR;
         ST_ERR:   state_in = ST_MAG;
         ST_MAG:   state_in = aw_ff ? ST_GT : ST_KP;
         ST_KP:    state_in = ST_GT;
         ST_GT:    state_in = ST_PL;
         ST_PL:    state_in = ST_PH;
         ST_PH:    state_in = ST_RND;
         ST_RND:   state_in = ST_ACC;
         ST_ACC: begin
            if (!aw_ff)       state_in = ST_SUM;
            else if (!loop_ff) state_in = ST_ERR;
            else               state_in = ST_DONE;
         end
         ST_SUM:   state_in = ST_CLAMP;
         ST_CLAMP: state_in = ST_MAG;
         ST_DONE:  if (done_go) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs: handshake and multiplier operands
   always_comb begin
      in_ready = 1'b0;
      mul_a    = '0;
      mul_b    = '0;
      unique case (state_ff)
         ST_IDLE: in_ready = 1'b1;
         ST_KP: begin
            mul_a = {1'b0, kp_sel};
            mul_b = mag_ff;
         end
         ST_GT: begin
            mul_a = {1'b0, gain_sel};
            mul_b = cfg.period;
         end
         ST_PL: begin
            mul_a = prod[31:0];
            mul_b = mag_ff;
         end
         ST_PH: begin
            mul_a = {1'b0, ph_ff};
            mul_b = mag_ff;
         end
         default: ;
      endcase
   end

   // datapath next values
   always_comb begin
      loop_in     = loop_ff;
      aw_in       = aw_ff;
      flx_tgt_in  = flx_tgt_ff;
      flx_meas_in = flx_meas_ff;
      spd_tgt_in  = spd_tgt_ff;
      spd_meas_in = spd_meas_ff;
      diff_in     = diff_ff;
      mag_in      = mag_ff;
      sgn_in      = sgn_ff;
      ph_in       = ph_ff;
      low_in      = low_ff;
      rnd_in      = rnd_ff;
      prop_in     = prop_ff;
      flx_int_in  = flx_int_ff;
      spd_int_in  = spd_int_ff;
      out_in      = out_ff;
      d_in        = d_ff;
      q_in        = q_ff;
      dflag_in    = dflag_ff;
      qflag_in    = qflag_ff;
      rsp_d_in    = rsp_d_ff;
      rsp_q_in    = rsp_q_ff;
      rsp_df_in   = rsp_df_ff;
      rsp_qf_in   = rsp_qf_ff;
      rsp_valid_in = (rsp_valid_ff && !out_ready);
      unique case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               flx_tgt_in  = in_flux_target;
               flx_meas_in = in_flux_measured;
               spd_tgt_in  = in_speed_target;
               spd_meas_in = in_speed_measured;
               loop_in     = 1'b0;
               aw_in       = 1'b0;
            end
         end
         ST_ERR: diff_in = err_raw;
         ST_MAG: begin
            if (diff_ff > ERR_HI) begin
               mag_in = ERR_HI[31:0];
               sgn_in = 1'b0;
            end else if (diff_ff < ERR_LO) begin
               mag_in = LO_MAG;
               sgn_in = 1'b1;
            end else begin
               mag_in = abs_diff[31:0];
               sgn_in = diff_ff[DW-1];
            end
         end
         ST_GT: if (!aw_ff) prop_in = p_sum[RW+15:16];
         ST_PL: ph_in = prod[62:32];
         ST_PH: low_in = prod + (64'd1 << 47);
         ST_RND: rnd_in = rnd_sum[RW+15:16];
         ST_ACC: begin
            if (loop_ff) spd_int_in = acc_sat;
            else         flx_int_in = acc_sat;
            if (aw_ff) begin
               aw_in   = 1'b0;
               loop_in = 1'b1;
            end
         end
         ST_SUM: begin
            if (sum_raw > S64_HI)      out_in = S64_HI[63:0];
            else if (sum_raw < S64_LO) out_in = S64_LO[63:0];
            else                       out_in = sum_raw[63:0];
         end
         ST_CLAMP: begin
            diff_in = DW'(out_ff) - clamp_ext;
            aw_in   = 1'b1;
            if (loop_ff) begin
               q_in     = clamped[31:0];
               qflag_in = clamp_hit;
            end else begin
               d_in     = clamped[31:0];
               dflag_in = clamp_hit;
            end
         end
         ST_DONE: begin
            if (done_go) begin
               rsp_valid_in = 1'b1;
               rsp_d_in     = d_ff;
               rsp_q_in     = q_ff;
               rsp_df_in    = dflag_ff;
               rsp_qf_in    = qflag_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         loop_ff      <= 1'b0;
         aw_ff        <= 1'b0;
         flx_int_ff   <= '0;
         spd_int_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         loop_ff      <= loop_in;
         aw_ff        <= aw_in;
         flx_int_ff   <= flx_int_in;
         spd_int_ff   <= spd_int_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      flx_tgt_ff  <= flx_tgt_in;
      flx_meas_ff <= flx_meas_in;
      spd_tgt_ff  <= spd_tgt_in;
      spd_meas_ff <= spd_meas_in;
      diff_ff     <= diff_in;
      mag_ff      <= mag_in;
      sgn_ff      <= sgn_in;
      ph_ff       <= ph_in;
      low_ff      <= low_in;
      rnd_ff      <= rnd_in;
      prop_ff     <= prop_in;
      out_ff      <= out_in;
      d_ff        <= d_in;
      q_ff        <= q_in;
      dflag_ff    <= dflag_in;
      qflag_ff    <= qflag_in;
      rsp_d_ff    <= rsp_d_in;
      rsp_q_ff    <= rsp_q_in;
      rsp_df_ff   <= rsp_df_in;
      rsp_qf_ff   <= rsp_qf_in;
   end

   assign out_valid         = rsp_valid_ff;
   assign out_d_ref         = rsp_d_ff;
   assign out_q_ref         = rsp_q_ff;
   assign out_flux_clamped  = rsp_df_ff;
   assign out_speed_clamped = rsp_qf_ff;

endmodule

>>> hw/rtl/dual_pi_antiwindup_controller_top.sv
// Channel | Direction | Ports                                        | Transfer when
// req     | in        | req_flux_/speed_ target and measured          | req_valid & req_ready
// rsp     | out       | rsp_d/q_current_ref, rsp_flux/speed_clamped   | rsp_valid & rsp_ready
// csr     | in        | csr_index, csr_wdata                          | csr_valid & csr_ready
//
// Each item runs 16 sequencer steps per loop, both loops in turn, with
// all products through one registered 32x32 multiplier. The result is
// registered in the final step. req_ready is high only while idle; a result
// waiting in the output register holds the sequencer in its last step only.
// Reset clears integrators, registers (period to 2.0e-4 s) and control state.
// Depends on dpi_pkg, dpi_csr, dpi_core (which instantiates dpi_mul).
module dual_pi_antiwindup_controller_top import dpi_pkg::*; #(
   parameter int DATA_WIDTH       = DATA_WIDTH_DEF,
   parameter int INTEGRATOR_WIDTH = INTEG_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic signed [31:0]   req_flux_target,
   input  logic signed [31:0]   req_flux_measured,
   input  logic signed [31:0]   req_speed_target,
   input  logic signed [31:0]   req_speed_measured,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic signed [31:0]   rsp_d_current_ref,
   output logic signed [31:0]   rsp_q_current_ref,
   output logic                 rsp_flux_clamped,
   output logic                 rsp_speed_clamped,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata
);

   cfg_type cfg;
   logic signed [31:0] lim_pos, lim_neg;

   dpi_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   dpi_core #(
      .DATA_WIDTH       (DATA_WIDTH),
      .INTEGRATOR_WIDTH (INTEGRATOR_WIDTH)
   ) u_core (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .in_valid          (req_valid),
      .in_ready          (req_ready),
      .in_flux_target    (req_flux_target),
      .in_flux_measured  (req_flux_measured),
      .in_speed_target   (req_speed_target),
      .in_speed_measured (req_speed_measured),
      .out_valid         (rsp_valid),
      .out_ready         (rsp_ready),
      .out_d_ref         (rsp_d_current_ref),
      .out_q_ref         (rsp_q_current_ref),
      .out_flux_clamped  (rsp_flux_clamped),
      .out_speed_clamped (rsp_speed_clamped)
   );

   assign lim_pos = $signed({1'b0, cfg.limit});
   assign lim_neg = -lim_pos;

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready stayed high after a req transfer");

   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("rsp_valid rose without an item in progress");

   a_flux_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_flux_clamped |->
         (rsp_d_current_ref == lim_pos) || (rsp_d_current_ref == lim_neg))
      else $error("flux clamp flag set but d reference is not at the limit");

   a_speed_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_speed_clamped |->
         (rsp_q_current_ref == lim_pos) || (rsp_q_current_ref == lim_neg))
      else $error("speed clamp flag set but q reference is not at the limit");

endmodule

>>> sim/dual_pi_antiwindup_controller_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for dual_pi_antiwindup_controller_top: directed and random samples
// against a bit-exact model of both PI loops with back-calculation anti-windup.
// Depends on dpi_pkg and the controller RTL; stands alone otherwise.
module dual_pi_antiwindup_controller_top_test;
   import dpi_pkg::*;

   localparam int ERR_W       = (DATA_WIDTH_DEF > 32) ? 32 : DATA_WIDTH_DEF;
   localparam int INTEG_W     = INTEG_WIDTH_DEF;
   localparam int CYCLE_LIMIT = 500000;
   localparam int DRAIN_WAIT  = 40;
   localparam int MAX_REPORTS = 10;

   localparam logic signed [31:0] S_MAX    = 32'sh7FFFFFFF;
   localparam logic signed [31:0] S_MIN    = 32'sh80000000;
   localparam logic signed [31:0] S_ONE    = 32'sh00010000;
   localparam logic [31:0]        GAIN_MAX = 32'h7FFFFFFF;
   localparam logic [31:0]        ONE_Q16  = 32'h00010000;
   localparam logic [31:0]        HALF_Q16 = 32'h00008000;

   typedef struct packed {
      logic signed [31:0] d_ref;
      logic signed [31:0] q_ref;
      logic               flux_hit;
      logic               speed_hit;
   } current_refs_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic               at_limit;
   } loop_out_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic signed [31:0]   req_flux_target;
   logic signed [31:0]   req_flux_measured;
   logic signed [31:0]   req_speed_target;
   logic signed [31:0]   req_speed_measured;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic signed [31:0]   rsp_d_current_ref;
   logic signed [31:0]   rsp_q_current_ref;
   logic                 rsp_flux_clamped;
   logic                 rsp_speed_clamped;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [31:0]          csr_wdata;

   cfg_type          shadow_cfg;
   longint           flux_integ;
   longint           speed_integ;
   current_refs_type pending_currents[$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int samples_sent   = 0;
   int settings_count = 0;
   int limited_results = 0;
   int mismatch_count = 0;
   int cycle_count    = 0;

   dual_pi_antiwindup_controller_top u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_flux_target    (req_flux_target),
      .req_flux_measured  (req_flux_measured),
      .req_speed_target   (req_speed_target),
      .req_speed_measured (req_speed_measured),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_d_current_ref  (rsp_d_current_ref),
      .rsp_q_current_ref  (rsp_q_current_ref),
      .rsp_flux_clamped   (rsp_flux_clamped),
      .rsp_speed_clamped  (rsp_speed_clamped),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  pending_currents.size());
         $display("dual_pi_antiwindup_controller_top_test: FAIL");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // ---------------------------------------------------------------- prediction

   function automatic longint clip_signed(input logic signed [127:0] v, input int w);
      logic signed [127:0] hi;
      hi = (128'sd1 <<< (w - 1)) - 128'sd1;
      if (v > hi) return longint'(hi);
      if (v < -hi - 128'sd1) return longint'(-hi - 128'sd1);
      return longint'(v);
   endfunction

   // gain (Q15.16) * period (Q0.32) * x (Q16.16), rounded half away to 16 fraction bits
   function automatic longint gain_period_product(input logic [GAIN_W-1:0] gain,
                                                  input logic [PERIOD_W-1:0] period,
                                                  input longint x);
      logic [127:0] mag_x;
      logic [127:0] prod;
      mag_x = (x < 0) ? 128'(-x) : 128'(x);
      prod = (128'(gain) * 128'(period) * mag_x + (128'd1 << 47)) >> 48;
      return (x < 0) ? -longint'(prod) : longint'(prod);
   endfunction

   function automatic longint prop_product(input logic [GAIN_W-1:0] gain, input longint x);
      logic [127:0] mag_x;
      logic [127:0] prod;
      mag_x = (x < 0) ? 128'(-x) : 128'(x);
      prod = (128'(gain) * mag_x + 128'd32768) >> 16;
      return (x < 0) ? -longint'(prod) : longint'(prod);
   endfunction

   function automatic loop_out_type pi_loop(input longint raw_err, input logic [GAIN_W-1:0] kp,
                                            input logic [GAIN_W-1:0] ki,
                                            input logic [GAIN_W-1:0] kaw, inout longint integ);
      longint       err;
      longint       lim;
      longint       unclamped;
      longint       held;
      longint       excess;
      loop_out_type res;
      lim = longint'(shadow_cfg.limit);
      err = clip_signed(128'(raw_err), ERR_W);
      integ = clip_signed(128'(integ) + 128'(gain_period_product(ki, shadow_cfg.period, err)),
                          INTEG_W);
      unclamped = clip_signed(128'(prop_product(kp, err)) + 128'(integ), 64);
      held = unclamped;
      res.at_limit = 1'b0;
      if (unclamped > lim) begin
         held = lim;
         res.at_limit = 1'b1;
      end else if (unclamped < -lim) begin
         held = -lim;
         res.at_limit = 1'b1;
      end
      excess = clip_signed(128'(unclamped) - 128'(held), ERR_W);
      integ = clip_signed(128'(integ) - 128'(gain_period_product(kaw, shadow_cfg.period, excess)),
                          INTEG_W);
      res.value = 32'(held);
      return res;
   endfunction

   function automatic current_refs_type predict_currents(input logic signed [31:0] ft,
                                                         input logic signed [31:0] fm,
                                                         input logic signed [31:0] st,
                                                         input logic signed [31:0] sm);
      loop_out_type     flux_out;
      loop_out_type     speed_out;
      current_refs_type res;
      flux_out = pi_loop(longint'(ft) - longint'(fm), shadow_cfg.flux_kp, shadow_cfg.flux_ki,
                         shadow_cfg.flux_kaw, flux_integ);
      speed_out = pi_loop(longint'(st) - longint'(sm), shadow_cfg.speed_kp, shadow_cfg.speed_ki,
                          shadow_cfg.speed_kaw, speed_integ);
      res.d_ref     = flux_out.value;
      res.q_ref     = speed_out.value;
      res.flux_hit  = flux_out.at_limit;
      res.speed_hit = speed_out.at_limit;
      if (res.flux_hit || res.speed_hit) limited_results++;
      return res;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string what, input current_refs_type want,
                                  input current_refs_type got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t %s: expected d=%h q=%h fc=%b sc=%b, got d=%h q=%h fc=%b sc=%b",
                  $realtime, what, want.d_ref, want.q_ref, want.flux_hit, want.speed_hit,
                  got.d_ref, got.q_ref, got.flux_hit, got.speed_hit);
   endtask

   always @(posedge clock) begin
      current_refs_type got;
      current_refs_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got.d_ref     = rsp_d_current_ref;
         got.q_ref     = rsp_q_current_ref;
         got.flux_hit  = rsp_flux_clamped;
         got.speed_hit = rsp_speed_clamped;
         if (pending_currents.size() == 0) begin
            want = '0;
            report_mismatch("result with no sample pending", want, got);
         end else begin
            want = pending_currents.pop_front();
            if (got !== want) report_mismatch("current reference mismatch", want, got);
         end
      end
   end

   // ---------------------------------------------------------------- drivers

   task automatic send_sample(input logic signed [31:0] ft, input logic signed [31:0] fm,
                              input logic signed [31:0] st, input logic signed [31:0] sm);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_flux_target    <= ft;
      req_flux_measured  <= fm;
      req_speed_target   <= st;
      req_speed_measured <= sm;
      do @(posedge clock); while (!req_ready);
      pending_currents.push_back(predict_currents(ft, fm, st, sm));
      samples_sent++;
   endtask

   task automatic wait_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_currents.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [31:0] data);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         csr_valid <= 1'b0;
         @(negedge clock);
      end
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_FLUX_KP:   shadow_cfg.flux_kp   = data[GAIN_W-1:0];
         CSR_FLUX_KI:   shadow_cfg.flux_ki   = data[GAIN_W-1:0];
         CSR_FLUX_KAW:  shadow_cfg.flux_kaw  = data[GAIN_W-1:0];
         CSR_SPEED_KP:  shadow_cfg.speed_kp  = data[GAIN_W-1:0];
         CSR_SPEED_KI:  shadow_cfg.speed_ki  = data[GAIN_W-1:0];
         CSR_SPEED_KAW: shadow_cfg.speed_kaw = data[GAIN_W-1:0];
         CSR_LIMIT:     shadow_cfg.limit     = data[GAIN_W-1:0];
         CSR_PERIOD:    shadow_cfg.period    = data[PERIOD_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic program_settings(input logic [31:0] fkp, input logic [31:0] fki,
                                   input logic [31:0] fkaw, input logic [31:0] skp,
                                   input logic [31:0] ski, input logic [31:0] skaw,
                                   input logic [31:0] limit, input logic [31:0] period);
      write_csr(CSR_FLUX_KP, fkp);
      write_csr(CSR_FLUX_KI, fki);
      write_csr(CSR_FLUX_KAW, fkaw);
      write_csr(CSR_SPEED_KP, skp);
      write_csr(CSR_SPEED_KI, ski);
      write_csr(CSR_SPEED_KAW, skaw);
      write_csr(CSR_LIMIT, limit);
      write_csr(CSR_PERIOD, period);
      settings_count++;
   endtask

   // ---------------------------------------------------------------- random values

   function automatic logic signed [31:0] pick_signal();
      case ($urandom_range(5))
         0, 1: return $urandom;
         2: return $signed($urandom_range(32'h001FFFFF)) - 32'sh00100000;
         3: begin
            case ($urandom_range(4))
               0: return S_MAX;
               1: return S_MIN;
               2: return 32'sd0;
               3: return -32'sd1;
               default: return 32'sd1;
            endcase
         end
         default: return $signed($urandom_range(32'h03FFFFFF)) - 32'sh02000000;
      endcase
   endfunction

   function automatic logic signed [31:0] near_value(input logic signed [31:0] v);
      return v + ($signed($urandom_range(32'h0001FFFF)) - 32'sh00010000);
   endfunction

   function automatic logic [31:0] pick_gain();
      case ($urandom_range(5))
         0: return 32'h0;
         1: return GAIN_MAX;
         2: return 32'hFFFFFFFF;
         3, 4: return $urandom_range(32'h00100000);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_limit();
      case ($urandom_range(5))
         0: return 32'h0;
         1: return GAIN_MAX;
         2, 3: return $urandom_range(32'h00400000);
         4: return $urandom_range(32'h04000000);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_period();
      case ($urandom_range(5))
         0: return PERIOD_RESET;
         1: return 32'hFFFFFFFF;
         2: return 32'h0;
         3, 4: return $urandom_range(32'h01000000);
         default: return $urandom;
      endcase
   endfunction

   // ---------------------------------------------------------------- tests

   task automatic test_reset_state();
      send_sample(S_MAX, S_MIN, S_MIN, S_MAX);
      send_sample(32'sd0, 32'sd0, 32'sd1, -32'sd1);
      wait_drain();
   endtask

   // bit 31 of the flux kp and speed kaw writes is set to check masking
   task automatic test_field_extremes();
      program_settings(32'h80010000, HALF_Q16, ONE_Q16, ONE_Q16, HALF_Q16, 32'hFFFF0000,
                       GAIN_MAX, PERIOD_RESET);
      send_sample(S_MAX, S_MIN, S_MIN, S_MAX);
      send_sample(S_MIN, S_MAX, S_MAX, S_MIN);
      send_sample(32'sd0, 32'sd0, 32'sd0, 32'sd0);
      send_sample(-32'sd1, 32'sd0, 32'sd1, 32'sd0);
      send_sample(S_MAX, S_MAX, S_MIN, S_MIN);
      send_sample(S_ONE, 32'sd0, -S_ONE, 32'sd0);
      wait_drain();
   endtask

   task automatic test_zero_limit();
      program_settings(ONE_Q16, 32'h0, 32'h0, ONE_Q16, 32'h0, 32'h0, 32'h0, PERIOD_RESET);
      send_sample(32'sd1, 32'sd0, 32'sd0, 32'sd1);
      send_sample(32'sd0, 32'sd0, 32'sd0, 32'sd0);
      send_sample(S_MAX, S_MIN, S_MIN, S_MAX);
      wait_drain();
   endtask

   task automatic test_overshoot_saturation();
      program_settings(GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX,
                       32'h00000100, 32'hFFFFFFFF);
      repeat (2) begin
         send_sample(S_MAX, S_MIN, S_MIN, S_MAX);
         send_sample(S_MIN, S_MAX, S_MAX, S_MIN);
      end
      wait_drain();
   endtask

   task automatic test_integrator_saturation();
      program_settings(32'h0, GAIN_MAX, 32'h0, 32'h0, GAIN_MAX, 32'h0, GAIN_MAX, 32'hFFFFFFFF);
      repeat (3) send_sample(S_MAX, S_MIN, S_MIN, S_MAX);
      repeat (3) send_sample(S_MIN, S_MAX, S_MAX, S_MIN);
      wait_drain();
   endtask

   task automatic test_random_phase(input int send_pct, input int recv_pct, input int count);
      int remaining;
      int batch;
      logic signed [31:0] ft;
      logic signed [31:0] fm;
      logic signed [31:0] st;
      logic signed [31:0] sm;
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      remaining = count;
      while (remaining > 0) begin
         program_settings(pick_gain(), pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                          pick_gain(), pick_limit(), pick_period());
         batch = $urandom_range(60, 20);
         if (batch > remaining) batch = remaining;
         repeat (batch) begin
            ft = pick_signal();
            st = pick_signal();
            fm = $urandom_range(1) ? near_value(ft) : pick_signal();
            sm = $urandom_range(1) ? near_value(st) : pick_signal();
            send_sample(ft, fm, st, sm);
         end
         remaining -= batch;
         wait_drain();
      end
   endtask

   initial begin
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_flux_target    = '0;
      req_flux_measured  = '0;
      req_speed_target   = '0;
      req_speed_measured = '0;
      csr_valid          = 1'b0;
      csr_index          = CSR_FLUX_KP;
      csr_wdata          = '0;
      shadow_cfg         = '0;
      shadow_cfg.period  = PERIOD_RESET;
      flux_integ         = 0;
      speed_integ        = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_field_extremes();
      test_zero_limit();
      test_overshoot_saturation();
      test_integrator_saturation();
      test_random_phase(22, 61, 170);
      test_random_phase(61, 22, 170);
      test_random_phase(0, 0, 160);

      repeat (DRAIN_WAIT) @(posedge clock);
      $display("covered %0d samples under %0d register settings, three pacing phases",
               samples_sent, settings_count);
      $display("%0d results had a loop at its limit; %0d mismatches, %0d results missing",
               limited_results, mismatch_count, pending_currents.size());
      if (mismatch_count == 0 && pending_currents.size() == 0)
         $display("dual_pi_antiwindup_controller_top_test: PASS");
      else
         $display("dual_pi_antiwindup_controller_top_test: FAIL");
      $finish;
   end

endmodule
